// File: rtl/gfjp_pkg.sv
// gf2 jump polynomial: shared types, constants and register indexes
// no dependencies; used by every module of the block
package gfjp_pkg;

    // exponent width and the width of the bit counter that walks it
    localparam int ADVANCE_BITS = 32;
    localparam int CNT_W        = $clog2(ADVANCE_BITS + 1);

    // polynomial widths
    localparam int HALF_W = 64;
    localparam int POLY_W = 128;
    localparam int PROD_W = 256;

    // configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_CHAR_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHAR_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MU_LOW      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MU_HIGH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MODE = 3'd4;

    // request into the shared carry-less multiplier
    typedef struct packed {
        logic              start;
        logic [POLY_W-1:0] a;
        logic [POLY_W-1:0] b;
    } clm_req_t;

    // response from the shared carry-less multiplier
    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] prod;
    } clm_rsp_t;

endpackage

// File: rtl/gf2_jump_polynomial.sv
// channel   | ports                                  | handshake
// ----------+----------------------------------------+------------------------------
// command   | advances                               | start, taken when busy low
// result    | jump_low, jump_high                    | done, one cycle, no stall
// config    | cfg_index, cfg_data                    | cfg_write, no wait
//
// a word runs from its accept to its done strobe as follows: a one-bit-per-cycle scan down
// to the top set bit (a zero count ends the scan with the result x), then per lower exponent
// bit a round: a dispatch state and three 128-bit carry-less products on the shared
// Karatsuba unit (three 64-bit passes each); the multiply by x folds into the last one.
// the round state posts the result once no bits remain; busy drops with done.
// reset clears the sequencer and the configuration registers; results cannot be stalled.
//
// top level: sequencer for left-to-right square-and-multiply with Barrett reduction
// depends on gfjp_pkg, gfjp_clmul128, gfjp_clmul64 and gfjp_mulx
module gf2_jump_polynomial
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [gfjp_pkg::ADVANCE_BITS-1:0] advances,
    output logic                              done,
    output logic [gfjp_pkg::HALF_W-1:0]       jump_low,
    output logic [gfjp_pkg::HALF_W-1:0]       jump_high,
    input  logic                              cfg_write,
    input  logic [gfjp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gfjp_pkg::HALF_W-1:0]       cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_SQ_P  = 3'd3;
    localparam logic [2:0] ST_SQ_Q  = 3'd4;
    localparam logic [2:0] ST_SQ_R  = 3'd5;

    localparam logic [gfjp_pkg::POLY_W-1:0] POLY_X = 128'd2;

    // configuration registers
    logic [gfjp_pkg::HALF_W-1:0] char_low_reg;
    logic [gfjp_pkg::HALF_W-1:0] char_high_reg;
    logic [gfjp_pkg::HALF_W-1:0] mu_low_reg;
    logic [gfjp_pkg::HALF_W-1:0] mu_high_reg;
    logic                        period_mode_reg;

    // sequencer state
    logic [2:0]                        state_reg;
    logic [2:0]                        state_next;
    logic [gfjp_pkg::ADVANCE_BITS-1:0] adv_reg;
    logic [gfjp_pkg::ADVANCE_BITS-1:0] adv_next;
    logic [gfjp_pkg::CNT_W-1:0]        cnt_reg;
    logic [gfjp_pkg::CNT_W-1:0]        cnt_next;
    logic [gfjp_pkg::POLY_W-1:0]       j_reg;
    logic [gfjp_pkg::POLY_W-1:0]       j_next;
    logic [gfjp_pkg::POLY_W-1:0]       pl_reg;
    logic [gfjp_pkg::POLY_W-1:0]       pl_next;
    logic [gfjp_pkg::POLY_W-1:0]       ph_reg;
    logic [gfjp_pkg::POLY_W-1:0]       ph_next;
    logic                              done_reg;
    logic                              done_next;
    logic [gfjp_pkg::POLY_W-1:0]       res_reg;
    logic [gfjp_pkg::POLY_W-1:0]       res_next;

    // datapath
    gfjp_pkg::clm_req_t          req;
    gfjp_pkg::clm_rsp_t          rsp;
    logic [gfjp_pkg::POLY_W-1:0] ch;
    logic [gfjp_pkg::POLY_W-1:0] mu;
    logic [gfjp_pkg::POLY_W-1:0] prod_hi;
    logic [gfjp_pkg::POLY_W-1:0] prod_shr;
    logic [gfjp_pkg::POLY_W-1:0] sq;
    logic [gfjp_pkg::POLY_W-1:0] sq_x;
    logic                        deg127;
    logic                        adv_top;

    assign ch       = {char_high_reg, char_low_reg};
    assign mu       = {mu_high_reg, mu_low_reg};
    assign deg127   = period_mode_reg;
    assign prod_hi  = rsp.prod[gfjp_pkg::PROD_W-1:gfjp_pkg::POLY_W];
    assign prod_shr = rsp.prod[gfjp_pkg::PROD_W-2:gfjp_pkg::POLY_W-1];
    assign adv_top  = adv_reg[gfjp_pkg::ADVANCE_BITS-1];

    // reduced square out of the last product
    always_comb
    begin
        sq = pl_reg ^ rsp.prod[gfjp_pkg::POLY_W-1:0];
        if (deg127)
        begin
            sq[gfjp_pkg::POLY_W-1] = 1'b0;
        end
    end

    gfjp_mulx u_mulx
    (
        .a      (sq),
        .ch     (ch),
        .deg127 (deg127),
        .y      (sq_x)
    );

    gfjp_clmul128 u_clmul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_low_reg    <= '0;
            char_high_reg   <= '0;
            mu_low_reg      <= '0;
            mu_high_reg     <= '0;
            period_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                gfjp_pkg::REG_CHAR_LOW:    char_low_reg    <= cfg_data;
                gfjp_pkg::REG_CHAR_HIGH:   char_high_reg   <= cfg_data;
                gfjp_pkg::REG_MU_LOW:      mu_low_reg      <= cfg_data;
                gfjp_pkg::REG_MU_HIGH:     mu_high_reg     <= cfg_data;
                gfjp_pkg::REG_PERIOD_MODE: period_mode_reg <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    // square-and-multiply sequencer
    always_comb
    begin
        state_next = state_reg;
        adv_next   = adv_reg;
        cnt_next   = cnt_reg;
        j_next     = j_reg;
        pl_next    = pl_reg;
        ph_next    = ph_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        req.start  = 1'b0;
        req.a      = j_reg;
        req.b      = j_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    adv_next   = advances;
                    cnt_next   = gfjp_pkg::CNT_W'(gfjp_pkg::ADVANCE_BITS);
                    j_next     = POLY_X;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == '0)
                begin
                    // zero count: result stays x
                    done_next  = 1'b1;
                    res_next   = j_reg;
                    state_next = ST_IDLE;
                end
                else
                begin
                    adv_next = {adv_reg[gfjp_pkg::ADVANCE_BITS-2:0], 1'b0};
                    cnt_next = cnt_reg - gfjp_pkg::CNT_W'(1);
                    if (adv_top)
                    begin
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_ROUND:
            begin
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    res_next   = j_reg;
                    state_next = ST_IDLE;
                end
                else
                begin
                    // full square of j
                    req.start  = 1'b1;
                    state_next = ST_SQ_P;
                end
            end
            ST_SQ_P:
            begin
                req.a = deg127 ? prod_shr : prod_hi;
                req.b = mu;
                if (rsp.done)
                begin
                    pl_next    = rsp.prod[gfjp_pkg::POLY_W-1:0];
                    ph_next    = prod_hi;
                    req.start  = 1'b1;
                    state_next = ST_SQ_Q;
                end
            end
            ST_SQ_Q:
            begin
                req.a = deg127 ? prod_shr : (prod_hi ^ ph_reg);
                req.b = ch;
                if (rsp.done)
                begin
                    req.start  = 1'b1;
                    state_next = ST_SQ_R;
                end
            end
            ST_SQ_R:
            begin
                if (rsp.done)
                begin
                    j_next     = adv_top ? sq_x : sq;
                    adv_next   = {adv_reg[gfjp_pkg::ADVANCE_BITS-2:0], 1'b0};
                    cnt_next   = cnt_reg - gfjp_pkg::CNT_W'(1);
                    state_next = ST_ROUND;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // working and result words
    always_ff @(posedge clk)
    begin
        adv_reg <= adv_next;
        j_reg   <= j_next;
        pl_reg  <= pl_next;
        ph_reg  <= ph_next;
        res_reg <= res_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign jump_low  = res_reg[gfjp_pkg::HALF_W-1:0];
    assign jump_high = res_reg[gfjp_pkg::POLY_W-1:gfjp_pkg::HALF_W];

endmodule

// File: rtl/gfjp_clmul64.sv
// gf2 jump polynomial: 64 x 64 carry-less multiplier, combinational
// depends on gfjp_pkg for widths
module gfjp_clmul64
(
    input  logic [gfjp_pkg::HALF_W-1:0] x,
    input  logic [gfjp_pkg::HALF_W-1:0] y,
    output logic [gfjp_pkg::POLY_W-1:0] p
);

    // xor of shifted partial products, one per bit of y
    always_comb
    begin
        logic [gfjp_pkg::POLY_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < gfjp_pkg::HALF_W; i++)
        begin
            acc = acc ^ (({{gfjp_pkg::HALF_W{1'b0}}, x} << i)
                         & {gfjp_pkg::POLY_W{y[i]}});
        end
        p = acc;
    end

endmodule

// File: rtl/gfjp_clmul128.sv
// gf2 jump polynomial: 128 x 128 carry-less product in three Karatsuba steps
// depends on gfjp_pkg and gfjp_clmul64 (one shared 64-bit multiplier)
module gfjp_clmul128
(
    input  logic                clk,
    input  logic                rst_n,
    input  gfjp_pkg::clm_req_t  req,
    output gfjp_pkg::clm_rsp_t  rsp
);

    localparam logic [1:0] STEP_LO  = 2'd0;
    localparam logic [1:0] STEP_HI  = 2'd1;
    localparam logic [1:0] STEP_MID = 2'd2;

    logic [gfjp_pkg::POLY_W-1:0] a_reg;
    logic [gfjp_pkg::POLY_W-1:0] b_reg;
    logic [gfjp_pkg::POLY_W-1:0] p_lo_reg;
    logic [gfjp_pkg::POLY_W-1:0] p_hi_reg;
    logic [gfjp_pkg::POLY_W-1:0] p_mid_reg;
    logic [1:0]                  step_reg;
    logic [1:0]                  step_next;
    logic                        run_reg;
    logic                        run_next;
    logic                        done_reg;
    logic                        done_next;
    logic [gfjp_pkg::HALF_W-1:0] mx;
    logic [gfjp_pkg::HALF_W-1:0] my;
    logic [gfjp_pkg::POLY_W-1:0] mp;
    logic [gfjp_pkg::POLY_W-1:0] mid;

    // operand select for the current step
    always_comb
    begin
        unique case (step_reg)
            STEP_LO:
            begin
                mx = a_reg[gfjp_pkg::HALF_W-1:0];
                my = b_reg[gfjp_pkg::HALF_W-1:0];
            end
            STEP_HI:
            begin
                mx = a_reg[gfjp_pkg::POLY_W-1:gfjp_pkg::HALF_W];
                my = b_reg[gfjp_pkg::POLY_W-1:gfjp_pkg::HALF_W];
            end
            default:
            begin
                mx = a_reg[gfjp_pkg::HALF_W-1:0] ^ a_reg[gfjp_pkg::POLY_W-1:gfjp_pkg::HALF_W];
                my = b_reg[gfjp_pkg::HALF_W-1:0] ^ b_reg[gfjp_pkg::POLY_W-1:gfjp_pkg::HALF_W];
            end
        endcase
    end

    gfjp_clmul64 u_mul
    (
        .x (mx),
        .y (my),
        .p (mp)
    );

    // step control
    always_comb
    begin
        step_next = step_reg;
        run_next  = run_reg;
        done_next = done_reg;
        if (req.start)
        begin
            step_next = STEP_LO;
            run_next  = 1'b1;
            done_next = 1'b0;
        end
        else if (run_reg)
        begin
            if (step_reg == STEP_MID)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_LO;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    // operand and partial product registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg <= req.a;
            b_reg <= req.b;
        end
        if (run_reg && !req.start)
        begin
            unique case (step_reg)
                STEP_LO:  p_lo_reg  <= mp;
                STEP_HI:  p_hi_reg  <= mp;
                default:  p_mid_reg <= mp;
            endcase
        end
    end

    // karatsuba recombine: middle term lands at bit 64
    assign mid      = p_mid_reg ^ p_lo_reg ^ p_hi_reg;
    assign rsp.done = done_reg;
    assign rsp.prod = {p_hi_reg, p_lo_reg}
                    ^ {{gfjp_pkg::HALF_W{1'b0}}, mid, {gfjp_pkg::HALF_W{1'b0}}};

endmodule

// File: rtl/gfjp_top_note.sv
// gf2 jump polynomial: characteristic multiply-by-x step
// depends on gfjp_pkg for widths
module gfjp_mulx
(
    input  logic [gfjp_pkg::POLY_W-1:0] a,
    input  logic [gfjp_pkg::POLY_W-1:0] ch,
    input  logic                        deg127,
    output logic [gfjp_pkg::POLY_W-1:0] y
);

    // shift by one, fold the characteristic back in on overflow
    always_comb
    begin
        logic [gfjp_pkg::POLY_W-1:0] n;
        logic                        fold;
        n    = {a[gfjp_pkg::POLY_W-2:0], 1'b0};
        fold = deg127 ? n[gfjp_pkg::POLY_W-1] : a[gfjp_pkg::POLY_W-1];
        if (fold)
        begin
            n = n ^ ch;
        end
        if (deg127)
        begin
            n[gfjp_pkg::POLY_W-1] = 1'b0;
        end
        y = n;
    end

endmodule
